>>> rtl/ordered_list_engine_defines.svh
// assertion macros shared by the ordered list engine rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// expression holds at every clock edge out of reset
`define OLE_ASSERT_HOLDS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("ole invariant violated");

// antecedent implies consequent in the same cycle
`define OLE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ole implication violated");

`endif

>>> rtl/ole_pkg.sv
// shared types and codes of the ordered list engine
// no dependencies; imported by the controller, datapath and top level
package ole_pkg;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_AFTER = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_END   = 3'd4,
        CMD_DEL_KEY   = 3'd5,
        CMD_SEARCH    = 3'd6,
        CMD_DUMP      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ALLOC,
        S_NODE,
        S_LINK,
        S_DEL_RD,
        S_DEL_CAP,
        S_UNLINK,
        S_WALK_RD,
        S_WALK,
        S_DUMP,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ALLOC,
        OP_NODE,
        OP_LINK,
        OP_DEL_RD,
        OP_DEL_CAP,
        OP_UNLINK,
        OP_WALK_RD,
        OP_WALK,
        OP_DUMP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
        logic    use_pos;
        logic    use_elem;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic hit;
        logic next_null;
        logic out_free;
    } dp_stat_t;

    localparam int IN_BITS  = 72;
    localparam int OUT_BITS = 48;

endpackage

>>> rtl/ordered_list_engine.sv
// Ordered list engine: bounded doubly linked list of signed 32-bit values.
// One command is taken on the s_ channel when s_tvalid and s_tready are high;
// s_tready is high only while the block is idle, so one command is in work
// at a time. Each command gives one result transaction on the m_ channel,
// except dump, which gives one per element with m_tlast on the final one.
// Inserts at front or end pass through the alloc, node and link steps;
// deletes at front or end through read, capture and unlink; empty or full
// answers go straight to the result. Key commands walk the list at one
// node per cycle (registered pool read feeding the next read address) until
// a match or the list end; insert-after then runs the insert steps.
// The output register lets a result wait while the engine returns to idle
// and takes the next command; when the receiver stalls, dump pauses and
// rereads the current node until the output register frees.
// After reset the list is empty and all CAPACITY nodes are free; the pool
// needs no clearing pass, so a command can be taken in the first cycle.
// Depends on ole_pkg, ole_ctrl, ole_datapath and ole_ram.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cmd[2:0], match_key[34:3], new_value[66:35], zero fill to 72
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[1:0], position[7:2], element[39:8], length[45:40], zero fill to 48
    output logic [OUT_BITS-1:0] m_tdata,
    output logic                m_tlast
);
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // command sequencer
    ole_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .ctrl(ctrl)
    );

    // node pool and result path
    ole_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .ctrl(ctrl), .stat(stat),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

>>> rtl/ole_ram.sv
// generic single write port ram with registered read
// no dependencies
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/ole_ctrl.sv
// sequencer of the ordered list engine: decides each command's steps
// depends on ole_pkg
module ole_ctrl
    import ole_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);
    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    upos_reg, upos_next;
    logic    uelem_reg, uelem_next;

    // state and result code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            upos_reg  <= 1'b0;
            uelem_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            upos_reg  <= upos_next;
            uelem_reg <= uelem_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        upos_next  = upos_reg;
        uelem_next = uelem_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                code_next  = ST_OK;
                upos_next  = 1'b0;
                uelem_next = 1'b0;
                priority if (stat.empty && stat.cmd != CMD_INS_FRONT
                             && stat.cmd != CMD_INS_END) begin
                    code_next  = ST_EMPTY;
                    state_next = S_EMIT;
                end else if (stat.full && (stat.cmd == CMD_INS_FRONT
                             || stat.cmd == CMD_INS_END || stat.cmd == CMD_INS_AFTER)) begin
                    code_next  = ST_FULL;
                    state_next = S_EMIT;
                end else begin
                    unique case (stat.cmd)
                        CMD_INS_FRONT, CMD_INS_END: state_next = S_ALLOC;
                        CMD_DEL_FRONT, CMD_DEL_END: state_next = S_DEL_RD;
                        default:                    state_next = S_WALK_RD;
                    endcase
                end
            end
            S_ALLOC:   state_next = S_NODE;
            S_NODE:    state_next = S_LINK;
            S_LINK:    state_next = S_EMIT;
            S_DEL_RD:  state_next = S_DEL_CAP;
            S_DEL_CAP: state_next = S_UNLINK;
            S_UNLINK: begin
                uelem_next = 1'b1;
                state_next = S_EMIT;
            end
            S_WALK_RD: begin
                state_next = (stat.cmd == CMD_DUMP) ? S_DUMP : S_WALK;
            end
            S_WALK: begin
                if (stat.hit) begin
                    unique case (stat.cmd)
                        CMD_INS_AFTER: state_next = S_ALLOC;
                        CMD_DEL_KEY:   state_next = S_UNLINK;
                        default: begin
                            upos_next  = 1'b1;
                            state_next = S_EMIT;
                        end
                    endcase
                end else if (stat.next_null) begin
                    code_next  = ST_NOTFOUND;
                    state_next = S_EMIT;
                end
            end
            S_DUMP: begin
                if (stat.out_free && stat.next_null) state_next = S_IDLE;
            end
            S_EMIT: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        s_tready      = 1'b0;
        ctrl.op       = OP_NONE;
        ctrl.code     = code_reg;
        ctrl.use_pos  = upos_reg;
        ctrl.use_elem = uelem_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) ctrl.op = OP_LOAD;
            end
            S_DECIDE:  ctrl.op = OP_NONE;
            S_ALLOC:   ctrl.op = OP_ALLOC;
            S_NODE:    ctrl.op = OP_NODE;
            S_LINK:    ctrl.op = OP_LINK;
            S_DEL_RD:  ctrl.op = OP_DEL_RD;
            S_DEL_CAP: ctrl.op = OP_DEL_CAP;
            S_UNLINK:  ctrl.op = OP_UNLINK;
            S_WALK_RD: ctrl.op = OP_WALK_RD;
            S_WALK:    ctrl.op = OP_WALK;
            S_DUMP:    ctrl.op = OP_DUMP;
            S_EMIT:    ctrl.op = OP_EMIT;
            default:   ctrl.op = OP_NONE;
        endcase
    end
endmodule

>>> rtl/ole_datapath.sv
// node pool, list pointers, walk logic and output register of the list engine
// depends on ole_pkg, ole_ram and ordered_list_engine_defines.svh
`include "ordered_list_engine_defines.svh"
module ole_datapath
    import ole_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [IN_BITS-1:0]  s_tdata,
    input  dp_ctrl_t            ctrl,
    output dp_stat_t            stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata,
    output logic                m_tlast
);
    localparam int PW = $clog2(CAPACITY);
    localparam int LW = PW + 1;
    localparam logic [LW-1:0] NIL = LW'(1) << PW;

    // link reset value: node i points to i+1, last node to null
    function automatic logic [LW-1:0] reset_link(input logic [PW-1:0] idx);
        logic [LW-1:0] nxt;
        nxt = LW'(idx) + LW'(1);
        return (nxt < LW'(CAPACITY)) ? nxt : NIL;
    endfunction

    cmd_t          cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   val_reg, val_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [LW-1:0] free_reg, free_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] q_reg, q_next;
    logic [LW-1:0] n_reg, n_next;
    logic [31:0]   elem_reg, elem_next;
    logic [PW-1:0] raddr_reg;
    logic          fvld_reg;
    logic [CAPACITY-1:0] fwd_written_reg;

    logic          tvalid_reg, tvalid_next;
    status_t       ostat_reg, ostat_next;
    logic [5:0]    opos_reg, opos_next;
    logic [31:0]   oelem_reg, oelem_next;
    logic [5:0]    olen_reg, olen_next;
    logic          olast_reg, olast_next;

    logic [PW-1:0] rd_addr;
    logic          val_we, fwd_we, bwd_we;
    logic [PW-1:0] val_wa, fwd_wa, bwd_wa;
    logic [31:0]   val_wd;
    logic [LW-1:0] fwd_wd, bwd_wd;
    logic [31:0]   val_q;
    logic [LW-1:0] fwd_q, bwd_q, fwd_out;
    logic          out_free;

    // node pool memories
    ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
        .aclk(aclk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
        .raddr(rd_addr), .rdata(val_q)
    );
    ole_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_fwd_ram (
        .aclk(aclk), .we(fwd_we), .waddr(fwd_wa), .wdata(fwd_wd),
        .raddr(rd_addr), .rdata(fwd_q)
    );
    ole_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_bwd_ram (
        .aclk(aclk), .we(bwd_we), .waddr(bwd_wa), .wdata(bwd_wd),
        .raddr(rd_addr), .rdata(bwd_q)
    );

    // unwritten forward links read as the initial free chain
    assign fwd_out  = fvld_reg ? fwd_q : reset_link(raddr_reg);
    assign out_free = !tvalid_reg || m_tready;

    assign stat.cmd       = cmd_reg;
    assign stat.empty     = head_reg[PW];
    assign stat.full      = free_reg[PW];
    assign stat.hit       = (val_q == key_reg);
    assign stat.next_null = fwd_out[PW];
    assign stat.out_free  = out_free;

    // step logic
    always_comb begin
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        elem_next  = elem_reg;
        rd_addr    = raddr_reg;
        val_we = 1'b0; val_wa = '0; val_wd = '0;
        fwd_we = 1'b0; fwd_wa = '0; fwd_wd = '0;
        bwd_we = 1'b0; bwd_wa = '0; bwd_wd = '0;
        tvalid_next = tvalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        opos_next   = opos_reg;
        oelem_next  = oelem_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        unique case (ctrl.op)
            OP_NONE: ;
            OP_LOAD: begin
                cmd_next = cmd_t'(s_tdata[2:0]);
                key_next = s_tdata[34:3];
                val_next = s_tdata[66:35];
            end
            OP_ALLOC: begin
                rd_addr = free_reg[PW-1:0];
                if (cmd_reg == CMD_INS_FRONT) begin
                    p_next = NIL;
                    q_next = head_reg;
                end else if (cmd_reg == CMD_INS_END) begin
                    p_next = tail_reg;
                    q_next = NIL;
                end
            end
            OP_NODE: begin
                n_next     = free_reg;
                free_next  = fwd_out;
                count_next = count_reg + LW'(1);
                val_we = 1'b1; val_wa = free_reg[PW-1:0]; val_wd = val_reg;
                fwd_we = 1'b1; fwd_wa = free_reg[PW-1:0]; fwd_wd = q_reg;
                bwd_we = 1'b1; bwd_wa = free_reg[PW-1:0]; bwd_wd = p_reg;
            end
            OP_LINK: begin
                if (p_reg[PW]) begin
                    head_next = n_reg;
                end else begin
                    fwd_we = 1'b1; fwd_wa = p_reg[PW-1:0]; fwd_wd = n_reg;
                end
                if (q_reg[PW]) begin
                    tail_next = n_reg;
                end else begin
                    bwd_we = 1'b1; bwd_wa = q_reg[PW-1:0]; bwd_wd = n_reg;
                end
            end
            OP_DEL_RD: begin
                rd_addr = (cmd_reg == CMD_DEL_FRONT) ? head_reg[PW-1:0] : tail_reg[PW-1:0];
            end
            OP_DEL_CAP: begin
                p_next     = bwd_q;
                q_next     = fwd_out;
                elem_next  = val_q;
                free_next  = {1'b0, raddr_reg};
                count_next = count_reg - LW'(1);
                fwd_we = 1'b1; fwd_wa = raddr_reg; fwd_wd = free_reg;
            end
            OP_UNLINK: begin
                if (p_reg[PW]) begin
                    head_next = q_reg;
                end else begin
                    fwd_we = 1'b1; fwd_wa = p_reg[PW-1:0]; fwd_wd = q_reg;
                end
                if (q_reg[PW]) begin
                    tail_next = p_reg;
                end else begin
                    bwd_we = 1'b1; bwd_wa = q_reg[PW-1:0]; bwd_wd = p_reg;
                end
            end
            OP_WALK_RD: begin
                rd_addr  = head_reg[PW-1:0];
                pos_next = LW'(1);
            end
            OP_WALK: begin
                if (stat.hit) begin
                    if (cmd_reg == CMD_INS_AFTER) begin
                        p_next = {1'b0, raddr_reg};
                        q_next = fwd_out;
                    end else if (cmd_reg == CMD_DEL_KEY) begin
                        p_next     = bwd_q;
                        q_next     = fwd_out;
                        elem_next  = val_q;
                        free_next  = {1'b0, raddr_reg};
                        count_next = count_reg - LW'(1);
                        fwd_we = 1'b1; fwd_wa = raddr_reg; fwd_wd = free_reg;
                    end
                end else begin
                    rd_addr  = fwd_out[PW-1:0];
                    pos_next = pos_reg + LW'(1);
                end
            end
            OP_DUMP: begin
                if (out_free) begin
                    tvalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    opos_next   = 6'(pos_reg);
                    oelem_next  = val_q;
                    olen_next   = 6'(count_reg);
                    olast_next  = fwd_out[PW];
                    rd_addr     = fwd_out[PW-1:0];
                    pos_next    = pos_reg + LW'(1);
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    tvalid_next = 1'b1;
                    ostat_next  = ctrl.code;
                    opos_next   = ctrl.use_pos ? 6'(pos_reg) : 6'd0;
                    oelem_next  = ctrl.use_elem ? elem_reg : 32'd0;
                    olen_next   = 6'(count_reg);
                    olast_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // list pointers, write marks and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= NIL;
            tail_reg        <= NIL;
            free_reg        <= '0;
            count_reg       <= '0;
            fwd_written_reg <= '0;
            tvalid_reg      <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
            tvalid_reg <= tvalid_next;
            if (fwd_we) fwd_written_reg[fwd_wa] <= 1'b1;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        n_reg     <= n_next;
        elem_reg  <= elem_next;
        raddr_reg <= rd_addr;
        fvld_reg  <= fwd_written_reg[rd_addr];
        ostat_reg <= ostat_next;
        opos_reg  <= opos_next;
        oelem_reg <= oelem_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, olen_reg, oelem_reg, opos_reg, ostat_reg};

    // list bookkeeping is consistent whenever no pointer update is under way
    `OLE_ASSERT_IMPL(a_head_vs_count, aclk, aresetn, ctrl.op == OP_NONE || ctrl.op == OP_LOAD || ctrl.op == OP_EMIT, head_reg[PW] == (count_reg == '0))
    `OLE_ASSERT_IMPL(a_tail_vs_count, aclk, aresetn, ctrl.op == OP_NONE || ctrl.op == OP_LOAD || ctrl.op == OP_EMIT, tail_reg[PW] == (count_reg == '0))
    `OLE_ASSERT_IMPL(a_full_count, aclk, aresetn, free_reg[PW], count_reg == LW'(CAPACITY))
endmodule
